// File: design/lfd_pkg.sv
// lfd_pkg: shared types, codes and helpers for the two-channel LED fader.
// No dependencies; imported by lfd_map, lfd_ramp and dual_channel_led_fade.
`timescale 1ns / 1ps

package lfd_pkg;

    localparam int LFD_FADE_STEPS = 100;
    localparam logic [7:0] DUTY_OFF = 8'hFF;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_SET   = 2'd2,
        KIND_OFF   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_COLD = 2'd0,
        MODE_WARM = 2'd1,
        MODE_MIX  = 2'd2,
        MODE_OFF  = 2'd3
    } t_mode;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] brightness;
        logic       turn_on;
    } t_in_word;

    typedef struct packed {
        logic [7:0] cold_duty;
        logic [7:0] warm_duty;
        logic       lit;
        logic       fading;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic step;
        logic finish;
        logic set;
        logic off;
    } t_ramp_ctl;

    // x / 3 for x < 512, by reciprocal multiply
    function automatic logic [7:0] div3(input logic [8:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

endpackage

// File: design/dual_channel_led_fade.sv
// dual_channel_led_fade: top level, event control, config register, handshake.
// Depends on lfd_pkg, lfd_map, lfd_ramp.
//
//  channel  | valid        | stall        | word
//  ---------+--------------+--------------+---------------------
//  input    | i_in_valid   | o_in_stall   | i_in_data  (t_in_word)
//  output   | o_out_valid  | i_out_stall  | o_out_data (t_out_word)
//  config   | i_cfg_we     | -            | i_cfg_data (color mode)
//
// One word per cycle; the result of a word is valid the cycle after it is taken.
// Path per word: mode mapping then a 15x23 reciprocal multiply for the fade step.
// The duty and flag registers are the result register; the input stalls only
// while a result is held by a stalled output.
// Synchronous reset: duties off, no fade, not lit, color mode cold only.
`timescale 1ns / 1ps

module dual_channel_led_fade
    import lfd_pkg::*;
#(
    parameter int FADE_STEPS = LFD_FADE_STEPS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_data,
    input  logic      i_in_valid,
    input  t_in_word  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_data,
    input  logic      i_out_stall
);

    localparam int NW = $clog2(FADE_STEPS + 1);

    t_mode         r_mode;
    logic [NW-1:0] r_step;
    logic          r_fading;
    logic          r_goal;
    logic          r_lit;
    logic          r_out_valid;

    logic          accept;
    logic          map_on;
    logic [7:0]    map_cold;
    logic [7:0]    map_warm;
    logic [NW-1:0] n_step;
    logic          done;
    logic          same_cold;
    logic          same_warm;
    logic [7:0]    duty_cold;
    logic [7:0]    duty_warm;
    t_ramp_ctl     ctl;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign map_on     = (i_in_data.kind == KIND_START) ? i_in_data.turn_on : 1'b1;
    assign n_step     = r_step + NW'(1);
    assign done       = (n_step >= NW'(FADE_STEPS));

    always_comb begin
        ctl.start  = accept && (i_in_data.kind == KIND_START);
        ctl.step   = accept && (i_in_data.kind == KIND_TICK) && r_fading && !done;
        ctl.finish = accept && (i_in_data.kind == KIND_TICK) && r_fading && done;
        ctl.set    = accept && (i_in_data.kind == KIND_SET) && (r_mode != MODE_OFF);
        ctl.off    = accept && (i_in_data.kind == KIND_OFF);
    end

    lfd_map u_map (
        .i_mode       (r_mode),
        .i_brightness (i_in_data.brightness),
        .i_on         (map_on),
        .o_cold       (map_cold),
        .o_warm       (map_warm)
    );

    lfd_ramp #(
        .FADE_STEPS (FADE_STEPS)
    ) u_ramp_cold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_target (map_cold),
        .i_level  (map_cold),
        .o_same   (same_cold),
        .o_duty   (duty_cold)
    );

    lfd_ramp #(
        .FADE_STEPS (FADE_STEPS)
    ) u_ramp_warm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_target (map_warm),
        .i_level  (map_warm),
        .o_same   (same_warm),
        .o_duty   (duty_warm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_COLD;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_fading    <= 1'b0;
            r_goal      <= 1'b0;
            r_lit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                unique case (i_in_data.kind)
                    KIND_TICK: begin
                        if (r_fading) begin
                            r_step <= n_step;
                            if (done) begin
                                r_fading <= 1'b0;
                                r_lit    <= r_goal;
                            end
                        end
                    end
                    KIND_START: begin
                        r_step   <= '0;
                        r_goal   <= i_in_data.turn_on;
                        r_lit    <= i_in_data.turn_on;
                        r_fading <= !(same_cold && same_warm);
                    end
                    KIND_SET: begin
                        r_fading <= 1'b0;
                    end
                    default: begin
                        r_fading <= 1'b0;
                        r_lit    <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_data.cold_duty = duty_cold;
    assign o_out_data.warm_duty = duty_warm;
    assign o_out_data.lit       = r_lit;
    assign o_out_data.fading    = r_fading;

endmodule

// File: design/lfd_map.sv
// lfd_map: maps a brightness and color mode to the cold/warm target duties.
// Depends on lfd_pkg.
`timescale 1ns / 1ps

module lfd_map
    import lfd_pkg::*;
(
    input  t_mode      i_mode,
    input  logic [7:0] i_brightness,
    input  logic       i_on,
    output logic [7:0] o_cold,
    output logic [7:0] o_warm
);

    always_comb begin
        o_cold = DUTY_OFF;
        o_warm = DUTY_OFF;
        if (i_on) begin
            unique case (i_mode)
                MODE_COLD: begin
                    o_cold = i_brightness;
                end
                MODE_WARM: begin
                    o_warm = i_brightness;
                end
                MODE_MIX: begin
                    o_cold = div3({i_brightness, 1'b0});
                    o_warm = div3({1'b0, i_brightness});
                end
                default: begin
                    o_cold = DUTY_OFF;
                    o_warm = DUTY_OFF;
                end
            endcase
        end
    end

endmodule

// File: design/lfd_ramp.sv
// lfd_ramp: one duty channel with its linear fade interpolator.
// Depends on lfd_pkg.
`timescale 1ns / 1ps

module lfd_ramp
    import lfd_pkg::*;
#(
    parameter int FADE_STEPS = LFD_FADE_STEPS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ramp_ctl  i_ctl,
    input  logic [7:0] i_target,
    input  logic [7:0] i_level,
    output logic       o_same,
    output logic [7:0] o_duty
);

    localparam int NW = $clog2(FADE_STEPS + 1);
    localparam int AW = 8 + NW;
    localparam int K  = AW + NW;
    localparam int MW = K + 1;
    localparam longint unsigned MVAL = ((64'd1 << K) + FADE_STEPS - 1) / FADE_STEPS;
    localparam logic [MW-1:0] RECIP = MW'(MVAL);

    logic [7:0]       r_now;
    logic [7:0]       r_from;
    logic [7:0]       r_to;
    logic [7:0]       r_dist;
    logic             r_neg;
    logic [AW-1:0]    r_acc;

    logic [AW-1:0]    n_acc;
    logic [AW+MW-1:0] prod;
    logic [7:0]       quot;
    logic [7:0]       n_now;
    logic [8:0]       diff;

    // running |delta| * step, divided by the step count via reciprocal
    assign n_acc = r_acc + AW'(r_dist);
    assign prod  = (AW+MW)'(n_acc) * (AW+MW)'(RECIP);
    assign quot  = prod[K +: 8];
    assign diff  = {1'b0, i_target} - {1'b0, r_now};
    assign o_same = (i_target == r_now);
    assign o_duty = r_now;

    always_comb begin
        n_now = r_now;
        priority if (i_ctl.off) begin
            n_now = DUTY_OFF;
        end else if (i_ctl.set) begin
            n_now = i_level;
        end else if (i_ctl.finish) begin
            n_now = r_to;
        end else if (i_ctl.step) begin
            n_now = r_neg ? (r_from - quot) : (r_from + quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= DUTY_OFF;
        end else begin
            r_now <= n_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_from <= r_now;
            r_to   <= i_target;
            r_neg  <= diff[8];
            r_dist <= diff[8] ? (r_now - i_target) : diff[7:0];
            r_acc  <= '0;
        end else if (i_ctl.step) begin
            r_acc  <= n_acc;
        end
    end

endmodule
